>>> hw/rtl/lzpd_pkg.sv
// Shared types and constants for the prefix-coded LZ decompressor.
// Used by lzpd_token_decode and lz_prefix_coded_decompressor; no dependencies.
`default_nettype none
package lzpd_pkg;

    localparam logic [12:0] CHECK_DEPTH = 13'h113F;
    localparam logic [7:0]  FILL_BYTE   = 8'hE5;
    localparam logic [6:0]  MAX_RESULTS = 7'd64;

    localparam logic [1:0] STAT_DATA     = 2'd0;
    localparam logic [1:0] STAT_DONE     = 2'd1;
    localparam logic [1:0] STAT_OVERRUN  = 2'd2;
    localparam logic [1:0] STAT_BADCOUNT = 2'd3;

    typedef enum logic [2:0] {
        TOK_NEED  = 3'd0,
        TOK_LIT   = 3'd1,
        TOK_DEPTH = 3'd2,
        TOK_COUNT = 3'd3,
        TOK_BAD   = 3'd4
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [4:0]  len;
        logic [12:0] depth;
        logic [9:0]  count;
        logic [7:0]  lit;
    } tok_t;

endpackage
`default_nettype wire

>>> hw/rtl/lzpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module lzpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/lzpd_token_decode.sv
// Decodes the next token at the bottom of the bit window.
// Depends on lzpd_pkg for the token struct.
`default_nettype none
module lzpd_token_decode (
    input  wire logic [31:0] window,
    input  wire logic [5:0]  held,
    input  wire logic        awaiting,
    output lzpd_pkg::tok_t   tok
);

    logic [3:0]  tz;
    logic [3:0]  avail;
    logic [4:0]  clen;
    logic [16:0] shifted;
    logic [8:0]  mask;
    logic [4:0]  dlen;
    logic [12:0] dval;

    always_comb
    begin
        // Trailing zeros of the low nine bits, nine when all are zero.
        tz = 4'd9;
        for (int i = 8; i >= 0; i--)
        begin
            if (window[i])
            begin
                tz = 4'(i);
            end
        end
        avail   = (held < 6'd9) ? held[3:0] : 4'd9;
        clen    = {tz, 1'b0} + 5'd1;
        shifted = window[16:0] >> (tz + 4'd1);
        mask    = 9'((10'd1 << tz) - 10'd1);

        if (window[1:0] == 2'b00)
        begin
            dlen = 5'd8;
            dval = {7'd0, window[7:2]};
        end
        else if (!window[2])
        begin
            dlen = 5'd11;
            dval = {5'd0, window[10:3]} + 13'h0040;
        end
        else
        begin
            dlen = 5'd15;
            dval = {1'b0, window[14:3]} + 13'h0140;
        end

        tok       = '0;
        tok.kind  = lzpd_pkg::TOK_NEED;
        tok.lit   = {window[0], window[8:2]};
        tok.depth = dval;
        tok.count = 10'((11'd1 << tz) + 11'd1 + {2'd0, shifted[8:0] & mask});

        if (!awaiting)
        begin
            if (held >= 6'd2)
            begin
                if (window[1:0] == 2'b01 || window[1:0] == 2'b10)
                begin
                    if (held >= 6'd9)
                    begin
                        tok.kind = lzpd_pkg::TOK_LIT;
                        tok.len  = 5'd9;
                    end
                end
                else if (window[1:0] == 2'b00 || held >= 6'd3)
                begin
                    if (held >= {1'b0, dlen})
                    begin
                        tok.kind = lzpd_pkg::TOK_DEPTH;
                        tok.len  = dlen;
                    end
                end
            end
        end
        else
        begin
            if (tz >= avail)
            begin
                if (held >= 6'd9)
                begin
                    tok.kind = lzpd_pkg::TOK_BAD;
                    tok.len  = 5'd9;
                end
            end
            else if (held >= {1'b0, clen})
            begin
                tok.kind = lzpd_pkg::TOK_COUNT;
                tok.len  = clen;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/lz_prefix_coded_decompressor.sv
// Top level of the prefix-coded LZ decompressor: sequencer, bit window, lanes.
// Depends on lzpd_pkg, lzpd_token_decode and lzpd_ram.
//
//  channel  | signals                          | direction | transfer when
//  ---------+----------------------------------+-----------+---------------------
//  input    | in_valid, in_stall, byte fields  | into blk  | in_valid & !in_stall
//  output   | out_valid, out_stall, fields     | out of    | out_valid & !out_stall
//  config   | cfg_valid, cfg_ready, cfg_data   | into blk  | cfg_valid & cfg_ready
//
// An input byte is accepted in ST_IDLE; ST_DECODE then takes each literal,
// depth or count token and moves to ST_FIN when the window runs short. Each
// copied byte is read from the history RAM in ST_COPY_RD and written in
// ST_COPY_WR; result groups are captured in ST_PUT and ST_FIN closes the step.
// The single history RAM port pair sets the copy rate. Results are held while
// out_stall is high. The history store needs no clearing pass after reset.
`default_nettype none
module lz_prefix_coded_decompressor #(
    parameter int HISTORY_BYTES = 8192,
    parameter int OUT_LANES     = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  compressed_byte,
    input  wire logic        chunk_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte_0,
    output logic [7:0]       out_byte_1,
    output logic [7:0]       out_byte_2,
    output logic [7:0]       out_byte_3,
    output logic [7:0]       out_byte_4,
    output logic [7:0]       out_byte_5,
    output logic [7:0]       out_byte_6,
    output logic [7:0]       out_byte_7,
    output logic [3:0]       valid_bytes,
    output logic [1:0]       status,
    output logic             last,
    output logic [15:0]      total_written,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int AW    = $clog2(HISTORY_BYTES);
    localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 8) ? 8 : OUT_LANES);
    localparam logic [3:0]  LANES_W = 4'(LANES);
    localparam logic [AW:0] HIST_W  = (AW+1)'(HISTORY_BYTES);
    localparam logic [AW-1:0] HIST_LAST = AW'(HISTORY_BYTES - 1);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DECODE  = 6'b000010,
        ST_COPY_RD = 6'b000100,
        ST_COPY_WR = 6'b001000,
        ST_PUT     = 6'b010000,
        ST_FIN     = 6'b100000
    } state_t;

    state_t        state_reg, state_next, ret_reg, ret_next;
    logic [31:0]   window_reg, window_next;
    logic [5:0]    held_reg, held_next;
    logic [15:0]   written_reg, written_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [12:0]   pdepth_reg, pdepth_next;
    logic          awaiting_reg, awaiting_next;
    logic          stopped_reg, stopped_next;
    logic [9:0]    copy_left_reg, copy_left_next;
    logic [7:0]    lane_reg [8];
    logic [7:0]    lane_next [8];
    logic [3:0]    lane_n_reg, lane_n_next;
    logic [1:0]    put_status_reg, put_status_next;
    logic [6:0]    res_n_reg, res_n_next;
    logic          res_have_reg, res_have_next;
    logic [7:0]    res_bytes_reg [8];
    logic [3:0]    res_nbytes_reg;
    logic [1:0]    res_status_reg;
    logic [15:0]   res_total_reg;
    logic [7:0]    out_bytes_reg [8];
    logic [3:0]    out_nbytes_reg;
    logic [1:0]    out_status_reg;
    logic          out_last_reg;
    logic [15:0]   out_total_reg;
    logic          out_valid_reg;
    logic [15:0]   chunk_size_reg;

    logic          in_fire, out_free, out_load, out_last_val, res_cap;
    logic          wb_en, lane_full;
    logic [7:0]    wb_data;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [AW:0]   rd_diff;
    logic          clr;
    logic [31:0]   w0;
    logic [5:0]    h0;
    lzpd_pkg::tok_t tok;

    lzpd_token_decode u_dec (
        .window   (window_reg),
        .held     (held_reg),
        .awaiting (awaiting_reg),
        .tok      (tok)
    );

    lzpd_ram #(.WIDTH(8), .DEPTH(HISTORY_BYTES)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (wb_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign lane_full = (lane_n_reg + 4'd1) >= LANES_W;

    // Read address wraps backward around the history store.
    assign rd_diff   = {1'b0, wr_addr_reg} - (AW+1)'(pdepth_reg);
    assign ram_raddr = rd_diff[AW] ? AW'(rd_diff + HIST_W) : rd_diff[AW-1:0];
    assign ram_we    = wb_en;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        window_next     = window_reg;
        held_next       = held_reg;
        written_next    = written_reg;
        wr_addr_next    = wr_addr_reg;
        pdepth_next     = pdepth_reg;
        awaiting_next   = awaiting_reg;
        stopped_next    = stopped_reg;
        copy_left_next  = copy_left_reg;
        lane_next       = lane_reg;
        lane_n_next     = lane_n_reg;
        put_status_next = put_status_reg;
        res_n_next      = res_n_reg;
        res_have_next   = res_have_reg;
        out_load        = 1'b0;
        out_last_val    = 1'b0;
        res_cap         = 1'b0;
        wb_en           = 1'b0;
        wb_data         = tok.lit;
        clr             = chunk_start;
        w0              = clr ? 32'd0 : window_reg;
        h0              = clr ? 6'd0 : held_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_n_next  = '0;
                    lane_n_next = '0;
                    if (clr)
                    begin
                        window_next   = '0;
                        held_next     = '0;
                        written_next  = '0;
                        wr_addr_next  = '0;
                        pdepth_next   = '0;
                        awaiting_next = 1'b0;
                        stopped_next  = 1'b0;
                    end
                    if (clr || !stopped_reg)
                    begin
                        if (h0 <= 6'd24)
                        begin
                            window_next = w0 | ({24'd0, compressed_byte} << h0);
                            held_next   = h0 + 6'd8;
                        end
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                unique case (tok.kind)
                    lzpd_pkg::TOK_NEED:
                    begin
                        state_next = ST_FIN;
                    end
                    lzpd_pkg::TOK_LIT:
                    begin
                        if (written_reg >= chunk_size_reg)
                        begin
                            put_status_next = lzpd_pkg::STAT_OVERRUN;
                            stopped_next    = 1'b1;
                            ret_next        = ST_FIN;
                            state_next      = ST_PUT;
                        end
                        else
                        begin
                            window_next = window_reg >> tok.len;
                            held_next   = held_reg - 6'(tok.len);
                            wb_en       = 1'b1;
                            if (lane_full)
                            begin
                                put_status_next = lzpd_pkg::STAT_DATA;
                                ret_next        = ST_DECODE;
                                state_next      = ST_PUT;
                            end
                        end
                    end
                    lzpd_pkg::TOK_DEPTH:
                    begin
                        window_next = window_reg >> tok.len;
                        held_next   = held_reg - 6'(tok.len);
                        if (tok.depth == 13'd0 ||
                            (tok.depth == lzpd_pkg::CHECK_DEPTH &&
                             written_reg == chunk_size_reg))
                        begin
                            put_status_next = lzpd_pkg::STAT_DONE;
                            stopped_next    = 1'b1;
                            ret_next        = ST_FIN;
                            state_next      = ST_PUT;
                        end
                        else if (tok.depth != lzpd_pkg::CHECK_DEPTH)
                        begin
                            pdepth_next   = tok.depth;
                            awaiting_next = 1'b1;
                        end
                    end
                    lzpd_pkg::TOK_COUNT:
                    begin
                        window_next    = window_reg >> tok.len;
                        held_next      = held_reg - 6'(tok.len);
                        awaiting_next  = 1'b0;
                        copy_left_next = tok.count;
                        state_next     = ST_COPY_RD;
                    end
                    lzpd_pkg::TOK_BAD:
                    begin
                        window_next     = window_reg >> tok.len;
                        held_next       = held_reg - 6'(tok.len);
                        awaiting_next   = 1'b0;
                        put_status_next = lzpd_pkg::STAT_BADCOUNT;
                        stopped_next    = 1'b1;
                        ret_next        = ST_FIN;
                        state_next      = ST_PUT;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_COPY_RD:
            begin
                if (copy_left_reg == 10'd0)
                begin
                    state_next = ST_DECODE;
                end
                else if (written_reg >= chunk_size_reg)
                begin
                    put_status_next = lzpd_pkg::STAT_OVERRUN;
                    stopped_next    = 1'b1;
                    ret_next        = ST_FIN;
                    state_next      = ST_PUT;
                end
                else
                begin
                    state_next = ST_COPY_WR;
                end
            end
            ST_COPY_WR:
            begin
                wb_en          = 1'b1;
                wb_data        = ({3'd0, pdepth_reg} > written_reg) ?
                                 lzpd_pkg::FILL_BYTE : ram_rdata;
                copy_left_next = copy_left_reg - 10'd1;
                if (lane_full)
                begin
                    put_status_next = lzpd_pkg::STAT_DATA;
                    ret_next        = ST_COPY_RD;
                    state_next      = ST_PUT;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_PUT:
            begin
                // Past the result cap the group is dropped and the held
                // result stays back so it can still be flagged last.
                if (res_n_reg >= lzpd_pkg::MAX_RESULTS)
                begin
                    lane_n_next = '0;
                    state_next  = ret_reg;
                end
                // The held result goes out first, so the newest one can
                // still be flagged last when the step ends.
                else if (!res_have_reg || out_free)
                begin
                    out_load      = res_have_reg;
                    res_cap       = 1'b1;
                    res_have_next = 1'b1;
                    res_n_next    = res_n_reg + 7'd1;
                    lane_n_next   = '0;
                    state_next    = ret_reg;
                end
            end
            ST_FIN:
            begin
                if (lane_n_reg != 4'd0)
                begin
                    put_status_next = lzpd_pkg::STAT_DATA;
                    ret_next        = ST_FIN;
                    state_next      = ST_PUT;
                end
                else if (!res_have_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_val  = 1'b1;
                    res_have_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wb_en)
        begin
            lane_next[lane_n_reg[2:0]] = wb_data;
            lane_n_next  = lane_n_reg + 4'd1;
            written_next = written_reg + 16'd1;
            wr_addr_next = (wr_addr_reg == HIST_LAST) ? '0 : wr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_FIN;
            window_reg     <= '0;
            held_reg       <= '0;
            written_reg    <= '0;
            wr_addr_reg    <= '0;
            pdepth_reg     <= '0;
            awaiting_reg   <= 1'b0;
            stopped_reg    <= 1'b0;
            copy_left_reg  <= '0;
            lane_n_reg     <= '0;
            put_status_reg <= lzpd_pkg::STAT_DATA;
            res_n_reg      <= '0;
            res_have_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            chunk_size_reg <= 16'd8192;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            window_reg     <= window_next;
            held_reg       <= held_next;
            written_reg    <= written_next;
            wr_addr_reg    <= wr_addr_next;
            pdepth_reg     <= pdepth_next;
            awaiting_reg   <= awaiting_next;
            stopped_reg    <= stopped_next;
            copy_left_reg  <= copy_left_next;
            lane_n_reg     <= lane_n_next;
            put_status_reg <= put_status_next;
            res_n_reg      <= res_n_next;
            res_have_reg   <= res_have_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                chunk_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        if (res_cap)
        begin
            for (int j = 0; j < 8; j++)
            begin
                res_bytes_reg[j] <= (4'(j) < lane_n_reg) ? lane_reg[j] : 8'd0;
            end
            res_nbytes_reg <= lane_n_reg;
            res_status_reg <= put_status_reg;
            res_total_reg  <= written_reg;
        end
        if (out_load)
        begin
            out_bytes_reg  <= res_bytes_reg;
            out_nbytes_reg <= res_nbytes_reg;
            out_status_reg <= res_status_reg;
            out_total_reg  <= res_total_reg;
            out_last_reg   <= out_last_val;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte_0    = out_bytes_reg[0];
    assign out_byte_1    = out_bytes_reg[1];
    assign out_byte_2    = out_bytes_reg[2];
    assign out_byte_3    = out_bytes_reg[3];
    assign out_byte_4    = out_bytes_reg[4];
    assign out_byte_5    = out_bytes_reg[5];
    assign out_byte_6    = out_bytes_reg[6];
    assign out_byte_7    = out_bytes_reg[7];
    assign valid_bytes   = out_nbytes_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;
    assign total_written = out_total_reg;

    a_lanes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        lane_n_reg <= LANES_W)
        else $error("lane count exceeds lane width");

    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !res_have_reg)
        else $error("result still held while accepting input");

    a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY_WR |-> copy_left_reg != 10'd0)
        else $error("copy write with nothing left to copy");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_PUT || $past(state_reg) == ST_FIN))
        else $error("output raised outside a result transfer");

endmodule
`default_nettype wire
